// ===== rtl/jot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jot_pkg;

    // Character classes that the front end hands to the parser.
    typedef enum logic [3:0] {
        CLS_LBRACE = 4'd0,
        CLS_RBRACE = 4'd1,
        CLS_QUOTE  = 4'd2,
        CLS_COLON  = 4'd3,
        CLS_LBRACK = 4'd4,
        CLS_RBRACK = 4'd5,
        CLS_COMMA  = 4'd6,
        CLS_DOT    = 4'd7,
        CLS_DIGIT  = 4'd8,
        CLS_WS     = 4'd9,
        CLS_OTHER  = 4'd10
    } cls_t;

    // Parser phases, one-hot.
    typedef enum logic [8:0] {
        PH_BRACE   = 9'b000000001,
        PH_KEYWAIT = 9'b000000010,
        PH_KEY     = 9'b000000100,
        PH_SEP     = 9'b000001000,
        PH_STR     = 9'b000010000,
        PH_NUM     = 9'b000100000,
        PH_AFTER   = 9'b001000000,
        PH_CLOSED  = 9'b010000000,
        PH_ERROR   = 9'b100000000
    } phase_t;

    localparam logic [3:0] EV_NONE   = 4'd0;
    localparam logic [3:0] EV_KEYCH  = 4'd1;
    localparam logic [3:0] EV_KEYEND = 4'd2;
    localparam logic [3:0] EV_STRCH  = 4'd3;
    localparam logic [3:0] EV_STREND = 4'd4;
    localparam logic [3:0] EV_NUMCH  = 4'd5;
    localparam logic [3:0] EV_LOPEN  = 4'd6;
    localparam logic [3:0] EV_LCLOSE = 4'd7;
    localparam logic [3:0] EV_ERR    = 4'd8;

    localparam logic [1:0] ND_NONE = 2'd0;
    localparam logic [1:0] ND_INT  = 2'd1;
    localparam logic [1:0] ND_REAL = 2'd2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One classified word on its way from the front end to the parser.
    typedef struct packed {
        logic       restart;
        cls_t       cls;
        logic [7:0] data;
    } tok_t;

    // One result word.
    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] data;
        logic [1:0] nd;
        logic       dd;
        logic       la;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/jot_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jot_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    byte_in,
    input  wire logic          restart,
    output logic               tok_valid,
    input  wire logic          tok_ready,
    output jot_pkg::tok_t      tok
);
    import jot_pkg::*;

    logic valid_reg;
    logic valid_next;
    tok_t tok_reg;
    cls_t cls;

    always_comb
    begin
        if (byte_in == CH_LBRACE)
            cls = CLS_LBRACE;
        else if (byte_in == CH_RBRACE)
            cls = CLS_RBRACE;
        else if (byte_in == CH_QUOTE)
            cls = CLS_QUOTE;
        else if (byte_in == CH_COLON)
            cls = CLS_COLON;
        else if (byte_in == CH_LBRACK)
            cls = CLS_LBRACK;
        else if (byte_in == CH_RBRACK)
            cls = CLS_RBRACK;
        else if (byte_in == CH_COMMA)
            cls = CLS_COMMA;
        else if (byte_in == CH_DOT)
            cls = CLS_DOT;
        else if (byte_in >= CH_ZERO && byte_in <= CH_NINE)
            cls = CLS_DIGIT;
        else if (byte_in == CH_SPACE || (byte_in >= CH_TAB && byte_in <= CH_CR))
            cls = CLS_WS;
        else
            cls = CLS_OTHER;
    end

    assign in_ready = !valid_reg || tok_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tok_reg.restart <= restart;
            tok_reg.cls     <= cls;
            tok_reg.data    <= byte_in;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/jot_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jot_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire jot_pkg::tok_t push_tok,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output jot_pkg::tok_t      pop_tok
);
    import jot_pkg::*;

    tok_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_tok;
    end

endmodule

`default_nettype wire

// ===== rtl/jot_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jot_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          tok_valid,
    output logic               tok_ready,
    input  wire jot_pkg::tok_t tok,
    output logic               res_valid,
    input  wire logic          res_ready,
    output jot_pkg::res_t      res
);
    import jot_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       in_list_reg;
    logic       in_list_next;
    logic       colon_reg;
    logic       colon_next;
    logic       dot_reg;
    logic       dot_next;
    logic       valid_reg;
    logic       valid_next;
    res_t       res_reg;
    res_t       res_next;

    phase_t     ph;
    logic       il;
    logic       cl;
    logic       dt;
    logic       err;
    logic [1:0] kind;
    logic       pop;

    assign tok_ready = !valid_reg || res_ready;
    assign pop       = tok_valid && tok_ready;

    always_comb
    begin
        // A restart word begins from the reset state.
        ph = tok.restart ? PH_BRACE : phase_reg;
        il = tok.restart ? 1'b0 : in_list_reg;
        cl = tok.restart ? 1'b0 : colon_reg;
        dt = tok.restart ? 1'b0 : dot_reg;

        phase_next   = ph;
        in_list_next = il;
        colon_next   = cl;
        dot_next     = dt;
        err          = 1'b0;
        kind         = dt ? ND_REAL : ND_INT;
        res_next.ev   = EV_NONE;
        res_next.data = tok.data;
        res_next.nd   = ND_NONE;
        res_next.dd   = 1'b0;

        case (ph)
            PH_BRACE:
            begin
                if (tok.cls == CLS_LBRACE)
                    phase_next = PH_KEYWAIT;
                else
                    err = 1'b1;
            end
            PH_KEYWAIT:
            begin
                if (tok.cls == CLS_QUOTE)
                    phase_next = PH_KEY;
                else if (tok.cls != CLS_WS)
                    err = 1'b1;
            end
            PH_KEY:
            begin
                if (tok.cls == CLS_QUOTE)
                begin
                    res_next.ev = EV_KEYEND;
                    phase_next  = PH_SEP;
                end
                else
                    res_next.ev = EV_KEYCH;
            end
            PH_SEP:
            begin
                case (tok.cls)
                    CLS_COLON:
                    begin
                        if (cl)
                            err = 1'b1;
                        else
                            colon_next = 1'b1;
                    end
                    CLS_QUOTE:
                    begin
                        if (cl)
                        begin
                            colon_next = 1'b0;
                            phase_next = PH_STR;
                        end
                        else
                            err = 1'b1;
                    end
                    CLS_LBRACK:
                    begin
                        if (!il && cl)
                        begin
                            in_list_next = 1'b1;
                            res_next.ev  = EV_LOPEN;
                        end
                        else
                            err = 1'b1;
                    end
                    CLS_DIGIT:
                    begin
                        if (cl)
                        begin
                            colon_next  = 1'b0;
                            dot_next    = 1'b0;
                            phase_next  = PH_NUM;
                            res_next.ev = EV_NUMCH;
                        end
                        else
                            err = 1'b1;
                    end
                    CLS_WS:
                    begin
                    end
                    default:
                        err = 1'b1;
                endcase
            end
            PH_STR:
            begin
                if (tok.cls == CLS_QUOTE)
                begin
                    res_next.ev = EV_STREND;
                    phase_next  = PH_AFTER;
                end
                else
                    res_next.ev = EV_STRCH;
            end
            PH_NUM:
            begin
                case (tok.cls)
                    CLS_DIGIT:
                        res_next.ev = EV_NUMCH;
                    CLS_DOT:
                    begin
                        if (dt)
                            err = 1'b1;
                        else
                        begin
                            dot_next    = 1'b1;
                            res_next.ev = EV_NUMCH;
                        end
                    end
                    CLS_WS:
                    begin
                        res_next.nd = kind;
                        phase_next  = PH_AFTER;
                    end
                    CLS_RBRACE:
                    begin
                        if (il)
                            err = 1'b1;
                        else
                        begin
                            res_next.nd = kind;
                            res_next.dd = 1'b1;
                            phase_next  = PH_CLOSED;
                        end
                    end
                    CLS_COMMA:
                    begin
                        res_next.nd = kind;
                        if (il)
                        begin
                            colon_next = 1'b1;
                            phase_next = PH_SEP;
                        end
                        else
                            phase_next = PH_KEYWAIT;
                    end
                    CLS_RBRACK:
                    begin
                        if (il)
                        begin
                            res_next.nd  = kind;
                            in_list_next = 1'b0;
                            res_next.ev  = EV_LCLOSE;
                            phase_next   = PH_AFTER;
                        end
                        else
                            err = 1'b1;
                    end
                    default:
                        err = 1'b1;
                endcase
            end
            PH_AFTER:
            begin
                case (tok.cls)
                    CLS_COMMA:
                    begin
                        if (il)
                        begin
                            colon_next = 1'b1;
                            phase_next = PH_SEP;
                        end
                        else
                            phase_next = PH_KEYWAIT;
                    end
                    CLS_RBRACE:
                    begin
                        if (il)
                            err = 1'b1;
                        else
                        begin
                            res_next.dd = 1'b1;
                            phase_next  = PH_CLOSED;
                        end
                    end
                    CLS_RBRACK:
                    begin
                        if (il)
                        begin
                            in_list_next = 1'b0;
                            res_next.ev  = EV_LCLOSE;
                        end
                        else
                            err = 1'b1;
                    end
                    CLS_WS:
                    begin
                    end
                    default:
                        err = 1'b1;
                endcase
            end
            PH_CLOSED:
            begin
            end
            default:
                err = 1'b1;
        endcase

        if (err)
        begin
            phase_next   = PH_ERROR;
            in_list_next = 1'b0;
            colon_next   = 1'b0;
            dot_next     = 1'b0;
            res_next.ev  = EV_ERR;
            res_next.nd  = ND_NONE;
            res_next.dd  = 1'b0;
        end

        // The list flag is already clear after an error or a close.
        res_next.la = in_list_next;

        valid_next = valid_reg;
        if (tok_ready)
            valid_next = tok_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BRACE;
            in_list_reg <= 1'b0;
            colon_reg   <= 1'b0;
            dot_reg     <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                phase_reg   <= phase_next;
                in_list_reg <= in_list_next;
                colon_reg   <= colon_next;
                dot_reg     <= dot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_next.ev == EV_ERR) |=> (phase_reg == PH_ERROR))
        else $error("error word did not leave the parser in the error phase");

    a_list_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_list_reg |-> (phase_reg == PH_SEP || phase_reg == PH_STR
                         || phase_reg == PH_NUM || phase_reg == PH_AFTER))
        else $error("list flag set outside a value phase");

    a_colon_phase: assert property (@(posedge clk) disable iff (!rst_n)
        colon_reg |-> (phase_reg == PH_SEP))
        else $error("colon flag set outside the separator phase");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.dd) |-> (res.ev == EV_NONE && !res.la))
        else $error("document close carries an event or an open list");

    a_close_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_next.dd) |=> (phase_reg == PH_CLOSED && !in_list_reg))
        else $error("document close did not reach the closed phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/json_object_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer for one flat JSON object, one byte per input word and one result word per
// input word. The front end registers each byte together with its character class, a
// four-entry queue decouples it from the parser, and the parser updates its phase and list,
// colon and decimal-point flags from the queue head and writes the result into an output
// register. With both sides always ready the block sustains one word per cycle; a word passes
// three registers in order (front register, queue, output register) before its result is on
// the output. The queue and the output register let the front end keep taking bytes while
// the result side stalls, up to six words in flight, after which in_ready drops. A word with
// restart set clears the parser state before its byte is parsed. Errors are sticky: every
// word after an error reports the error event until the next restart, and after the closing
// brace every word reports nothing.
module json_object_tokenizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       restart,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      event_res,
    output logic [7:0]      byte_out,
    output logic [1:0]      number_done,
    output logic            doc_done,
    output logic            list_active
);
    import jot_pkg::*;

    logic f_valid;
    logic f_ready;
    tok_t f_tok;
    logic q_valid;
    logic q_ready;
    tok_t q_tok;
    res_t res;

    // Front end: registers each byte with its character class.
    jot_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .restart   (restart),
        .tok_valid (f_valid),
        .tok_ready (f_ready),
        .tok       (f_tok)
    );

    // Short queue so that either side can stall without stopping the other at once.
    jot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_tok   (f_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_tok    (q_tok)
    );

    // Back end: the grammar state machine and the output register.
    jot_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign event_res   = res.ev;
    assign byte_out    = res.data;
    assign number_done = res.nd;
    assign doc_done    = res.dd;
    assign list_active = res.la;

endmodule

`default_nettype wire

// ===== bench/tb_json_object_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_json_object_tokenizer;
    import jot_pkg::*;

    // The run is stopped by force once this many clock cycles have passed.
    localparam int CYCLE_LIMIT = 200000;
    // Roughly how many text words the random part of the stimulus offers.
    localparam int RANDOM_WORDS = 1850;
    // A long receiver hold-off starts once this many words have been sent,
    // and a second one later on.
    localparam int HOLD_FIRST  = 300;
    localparam int HOLD_SECOND = 1400;
    localparam int HOLD_CYCLES = 150;
    // Printing stops after this many mismatch lines so a broken build stays readable.
    localparam int MAX_REPORTS = 200;

    localparam logic [7:0] WS_CHARS [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
    localparam logic [7:0] PUNCT_CHARS [9] = '{CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_COLON,
                                               CH_LBRACK, CH_RBRACK, CH_COMMA, CH_DOT,
                                               CH_ZERO};

    // Receiver behavior; each one is kept for a random number of cycles.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    // One word of JSON text as the sender offers it.
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } text_word_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte_in = 8'h00;
    logic       restart = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] event_res;
    logic [7:0] byte_out;
    logic [1:0] number_done;
    logic       doc_done;
    logic       list_active;

    json_object_tokenizer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .byte_out   (byte_out),
        .number_done(number_done),
        .doc_done   (doc_done),
        .list_active(list_active)
    );

    // Text words still to be offered, and the document under construction.
    text_word_t  text_words[$];
    logic [7:0]  doc_bytes[$];
    // Token words that the tokenizer owes us, oldest first.
    res_t        expected_tokens[$];

    // Our own copy of the tokenizer state, advanced once per accepted word.
    phase_t      tok_phase = PH_BRACE;
    logic        tok_in_list = 1'b0;
    logic        tok_colon = 1'b0;
    logic        tok_dot = 1'b0;
    logic        tok_last_dot = 1'b0;

    int          words_sent = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    int          objects_closed = 0;
    int          ints_done = 0;
    int          reals_done = 0;
    int          error_words = 0;
    int          list_closes = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Advances the tokenizer state by one text word and returns the token word it causes.
    function automatic res_t predict_word(logic [7:0] c, logic new_doc);
        res_t       tok;
        logic       err;
        logic [1:0] kind;
        tok.ev = EV_NONE;
        tok.data = c;
        tok.nd = ND_NONE;
        tok.dd = 1'b0;
        tok.la = 1'b0;
        err = 1'b0;
        if (new_doc)
        begin
            tok_phase = PH_BRACE;
            tok_in_list = 1'b0;
            tok_colon = 1'b0;
            tok_dot = 1'b0;
            tok_last_dot = 1'b0;
        end
        // The kind of a number is decided by the dot seen before the finishing byte.
        kind = tok_dot ? ND_REAL : ND_INT;
        case (tok_phase)
            PH_BRACE:
                if (c == CH_LBRACE)
                    tok_phase = PH_KEYWAIT;
                else
                    err = 1'b1;
            PH_KEYWAIT:
                if (c == CH_QUOTE)
                    tok_phase = PH_KEY;
                else if (!is_ws(c))
                    err = 1'b1;
            PH_KEY:
                if (c == CH_QUOTE)
                begin
                    tok.ev = EV_KEYEND;
                    tok_phase = PH_SEP;
                end
                else
                    tok.ev = EV_KEYCH;
            PH_SEP:
                // The colon flag is also set inside a list, where it means a value may follow.
                if (c == CH_COLON)
                begin
                    if (tok_colon)
                        err = 1'b1;
                    else
                        tok_colon = 1'b1;
                end
                else if (c == CH_QUOTE)
                begin
                    if (tok_colon)
                    begin
                        tok_colon = 1'b0;
                        tok_phase = PH_STR;
                    end
                    else
                        err = 1'b1;
                end
                else if (c == CH_LBRACK)
                begin
                    if (!tok_in_list && tok_colon)
                    begin
                        tok_in_list = 1'b1;
                        tok.ev = EV_LOPEN;
                    end
                    else
                        err = 1'b1;
                end
                else if (is_digit(c))
                begin
                    if (tok_colon)
                    begin
                        tok_colon = 1'b0;
                        tok_dot = 1'b0;
                        tok_last_dot = 1'b0;
                        tok_phase = PH_NUM;
                        tok.ev = EV_NUMCH;
                    end
                    else
                        err = 1'b1;
                end
                else if (!is_ws(c))
                    err = 1'b1;
            PH_STR:
                if (c == CH_QUOTE)
                begin
                    tok.ev = EV_STREND;
                    tok_phase = PH_AFTER;
                end
                else
                    tok.ev = EV_STRCH;
            PH_NUM:
                if (is_digit(c))
                begin
                    tok.ev = EV_NUMCH;
                    tok_last_dot = 1'b0;
                end
                else if (c == CH_DOT)
                begin
                    if (tok_dot)
                        err = 1'b1;
                    else
                    begin
                        tok_dot = 1'b1;
                        tok_last_dot = 1'b1;
                        tok.ev = EV_NUMCH;
                    end
                end
                else if (is_ws(c))
                begin
                    tok.nd = kind;
                    tok_phase = PH_AFTER;
                end
                else if (c == CH_RBRACE)
                begin
                    // A brace right after a number closes the object, but not inside a list.
                    if (tok_in_list)
                        err = 1'b1;
                    else
                    begin
                        tok.nd = kind;
                        tok.dd = 1'b1;
                        tok_phase = PH_CLOSED;
                    end
                end
                else if (c == CH_COMMA)
                begin
                    tok.nd = kind;
                    if (tok_in_list)
                    begin
                        tok_colon = 1'b1;
                        tok_phase = PH_SEP;
                    end
                    else
                        tok_phase = PH_KEYWAIT;
                end
                else if (c == CH_RBRACK)
                begin
                    if (tok_in_list)
                    begin
                        tok.nd = kind;
                        tok_in_list = 1'b0;
                        tok.ev = EV_LCLOSE;
                        tok_phase = PH_AFTER;
                    end
                    else
                        err = 1'b1;
                end
                else
                    err = 1'b1;
            PH_AFTER:
                if (c == CH_COMMA)
                begin
                    if (tok_in_list)
                    begin
                        tok_colon = 1'b1;
                        tok_phase = PH_SEP;
                    end
                    else
                        tok_phase = PH_KEYWAIT;
                end
                else if (c == CH_RBRACE)
                begin
                    if (tok_in_list)
                        err = 1'b1;
                    else
                    begin
                        tok.dd = 1'b1;
                        tok_phase = PH_CLOSED;
                    end
                end
                else if (c == CH_RBRACK)
                begin
                    if (tok_in_list)
                    begin
                        tok_in_list = 1'b0;
                        tok.ev = EV_LCLOSE;
                    end
                    else
                        err = 1'b1;
                end
                else if (!is_ws(c))
                    err = 1'b1;
            PH_CLOSED:
                ;
            default:
                err = 1'b1;
        endcase
        // Errors are sticky and clear every flag until the next restart.
        if (err)
        begin
            tok_phase = PH_ERROR;
            tok_in_list = 1'b0;
            tok_colon = 1'b0;
            tok_dot = 1'b0;
            tok_last_dot = 1'b0;
            tok.ev = EV_ERR;
            tok.nd = ND_NONE;
            tok.dd = 1'b0;
        end
        tok.la = (tok_phase == PH_CLOSED || err) ? 1'b0 : tok_in_list;
        return tok;
    endfunction

    //------------------------------------------------------------------
    // Document generation
    //------------------------------------------------------------------

    // Appends one byte to the document under construction.
    task automatic put_byte(logic [7:0] c);
        doc_bytes.insert(doc_bytes.size(), c);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // Up to two whitespace bytes, often none at all.
    task automatic put_ws();
        int n;
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
        repeat (n)
            put_byte(WS_CHARS[$urandom_range(0, 5)]);
    endtask

    // Body of a key or string: any byte but the quote, the full 8-bit range included.
    task automatic put_quoted();
        logic [7:0] c;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4))
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_QUOTE)
                c = c ^ 8'h01;
            put_byte(c);
        end
        put_byte(CH_QUOTE);
    endtask

    // Unsigned digit run, sometimes with one dot; a trailing dot is legal.
    task automatic put_number();
        repeat ($urandom_range(1, 4))
            put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1)
        begin
            put_byte(CH_DOT);
            repeat ($urandom_range(0, 3))
                put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic put_scalar();
        if ($urandom_range(0, 1) == 0)
            put_quoted();
        else
            put_number();
    endtask

    task automatic put_value();
        int n;
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            put_byte(CH_LBRACK);
            for (int i = 0; i < n; i++)
            begin
                put_ws();
                if (i > 0)
                begin
                    put_byte(CH_COMMA);
                    put_ws();
                end
                put_scalar();
            end
            put_ws();
            put_byte(CH_RBRACK);
        end
        else
            put_scalar();
    endtask

    // A well-formed flat object with one to four members.
    task automatic put_object();
        int n;
        n = $urandom_range(1, 4);
        put_byte(CH_LBRACE);
        for (int i = 0; i < n; i++)
        begin
            put_ws();
            if (i > 0)
            begin
                put_byte(CH_COMMA);
                put_ws();
            end
            put_quoted();
            put_ws();
            put_byte(CH_COLON);
            put_ws();
            put_value();
        end
        put_ws();
        put_byte(CH_RBRACE);
    endtask

    // Damages a built document in one place: a random byte, an extra punctuation byte,
    // a lost byte, or a cut.
    task automatic damage_doc();
        int idx;
        idx = $urandom_range(1, doc_bytes.size() - 1);
        case ($urandom_range(0, 3))
            0: doc_bytes[idx] = 8'($urandom_range(0, 255));
            1: doc_bytes.insert(idx, PUNCT_CHARS[$urandom_range(0, 8)]);
            2: doc_bytes.delete(idx);
            default:
                while (doc_bytes.size() > idx)
                    doc_bytes.delete(doc_bytes.size() - 1);
        endcase
    endtask

    // Short documents that each break one grammar rule.
    task automatic put_broken();
        case ($urandom_range(0, 8))
            0: put_str("{}");
            1: put_str("{\"a\":[]}");
            2: put_str("{\"a\":[1,]}");
            3: put_str("{\"a\"::1}");
            4: put_str("{\"a\":1.2.3}");
            5: put_str("{\"a\":[1}");
            6: put_str("{\"a\":[[1]]}");
            7: put_str("{\"a\":\"x\"}}");
            default: put_str("{\"a\"1}");
        endcase
    endtask

    // Moves the document into the send queue; restart marks its first byte only.
    task automatic flush_doc(logic first_restart);
        text_word_t w;
        for (int i = 0; i < doc_bytes.size(); i++)
        begin
            w.restart = (i == 0) ? first_restart : 1'b0;
            w.data = doc_bytes[i];
            text_words.insert(text_words.size(), w);
        end
        doc_bytes.delete();
    endtask

    task automatic put_noise();
        text_word_t w;
        repeat ($urandom_range(1, 6))
        begin
            w.restart = ($urandom_range(0, 3) == 0);
            w.data = 8'($urandom_range(0, 255));
            text_words.insert(text_words.size(), w);
        end
    endtask

    //------------------------------------------------------------------
    // Stimulus and end of run
    //------------------------------------------------------------------

    initial
    begin
        int pick;
        int target;

        // Straight out of reset, without restart: a key made of the top byte, a list with a
        // real number that ends in a dot and a string holding the zero byte.
        put_str("{\"");
        put_byte(8'hFF);
        put_str("\":[1.,\"");
        put_byte(8'h00);
        put_str("\"]}");
        flush_doc(1'b0);
        // A byte after the object has closed is ignored.
        put_str("x");
        flush_doc(1'b0);
        // A restart that does not begin with a brace, then the error sticks.
        put_str("}");
        put_byte(8'hFF);
        flush_doc(1'b1);
        // A brace right after an integer closes the object.
        put_str("{\"a\":7}");
        flush_doc(1'b1);

        // Mostly well-formed objects with random content, some damaged, some broken on
        // purpose, and a little plain noise.
        target = text_words.size() + RANDOM_WORDS;
        while (text_words.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                put_noise();
            else
            begin
                if (pick < 20)
                    put_broken();
                else
                begin
                    put_object();
                    if ($urandom_range(0, 3) == 0)
                        damage_doc();
                end
                flush_doc($urandom_range(0, 7) != 0);
                // Trailing bytes after the closing brace.
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                        put_byte(8'($urandom_range(0, 255)));
                    flush_doc(1'b0);
                end
            end
        end

        wait (rst_n);
        while (text_words.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_tokens.size() > 0)
            @(posedge clk);
        // The block holds at most six words; give any stray word time to show up.
        repeat (16) @(posedge clk);

        $display("run covered %0d words: %0d objects closed, %0d integers, %0d reals,",
                 words_sent, objects_closed, ints_done, reals_done);
        $display("  %0d list closes, %0d error words, %0d long receiver hold-offs",
                 list_closes, error_words, holds_done);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d token words outstanding",
                     cycle_count, expected_tokens.size());
            $display("tb: failure");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sender: words go out in bursts of random length with random gaps in between.
    // The prediction is made at the edge where a word is accepted.
    //------------------------------------------------------------------

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        text_word_t w;
        logic       offer_next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            byte_in <= 8'h00;
            restart <= 1'b0;
        end
        else
        begin
            offer_next = 1'b1;
            if (in_valid && in_ready)
            begin
                expected_tokens.insert(expected_tokens.size(), predict_word(byte_in, restart));
                words_sent <= words_sent + 1;
            end
            else if (in_valid)
                offer_next = 1'b0;
            // A word that has not been taken stays on the bus unchanged.
            if (offer_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (text_words.size() > 0)
                begin
                    w = text_words.pop_front();
                    in_valid <= 1'b1;
                    byte_in <= w.data;
                    restart <= w.restart;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver: a stall pattern that is drawn anew at random intervals, plus two long
    // hold-offs during which the sender keeps offering words until the tokenizer fills
    // up and drops in_ready.
    //------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 &&
                 words_sent >= ((holds_done == 0) ? HOLD_FIRST : HOLD_SECOND))
        begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    rx_mode_t rx_mode = RX_STEADY;
    int       rx_mode_left = 0;
    int       rx_tick = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic ready_now;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
            end
            else
                rx_mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_STEADY:   ready_now = 1'b1;
                RX_LIGHT:    ready_now = ($urandom_range(0, 3) != 0);
                RX_HEAVY:    ready_now = ($urandom_range(0, 3) == 0);
                default:     ready_now = (rx_tick % 3 == 0);
            endcase
            out_ready <= (hold_left == 0) && ready_now;
        end
    end

    //------------------------------------------------------------------
    // Monitor: every accepted token word is checked field by field against the oldest
    // prediction.
    //------------------------------------------------------------------

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                fail_count++;
                $display("%t: token word with nothing expected, actual event %0d byte %0d",
                         $time, event_res, byte_out);
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("event_res", int'(want.ev), int'(event_res));
                check_field("byte_out", int'(want.data), int'(byte_out));
                check_field("number_done", int'(want.nd), int'(number_done));
                check_field("doc_done", int'(want.dd), int'(doc_done));
                check_field("list_active", int'(want.la), int'(list_active));
            end
            if (doc_done)
                objects_closed++;
            if (number_done == ND_INT)
                ints_done++;
            if (number_done == ND_REAL)
                reals_done++;
            if (event_res == EV_ERR)
                error_words++;
            if (event_res == EV_LCLOSE)
                list_closes++;
        end
    end

endmodule
